// ----- hdl/tdl_pkg.sv -----
// shared constants, types and helpers for the tapped delay line
package tdl_pkg;

	localparam int MAX_LAG     = 31;
	localparam int LANES       = 4;
	localparam int MAX_TAPS    = 8;
	localparam int DEPTH       = MAX_LAG + 1;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int SAMPLE_W    = 16;
	localparam int LAG_FIELD_W = 5;
	localparam int LAG_WORDS   = 8;
	localparam int LAGS_W      = LAG_FIELD_W * LAG_WORDS;
	localparam int TAP_W       = 3;
	localparam int TCNT_W      = 4;
	localparam int VEC_W       = LANES * SAMPLE_W;
	localparam int IN_USER_W   = 1;
	localparam int OUT_USER_W  = 1 + TAP_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = LAGS_W;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_LAGS    = 2'd3;

	// item kinds
	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// sleep modes
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_FIXED = 2'd1;
	localparam logic [1:0] MODE_FIRST = 2'd2;

	typedef logic [LANES-1:0][SAMPLE_W-1:0] vec_t;

	typedef struct packed {
		logic                push;
		logic                restart;
		logic                spread;
		vec_t                sample;
		logic [SAMPLE_W-1:0] fill;
	} hist_ctl_t;

	// lag word of tap k, saturated to the deepest slot of the history (MAX_LAG)
	function automatic logic [IDX_W-1:0] tap_lag(input logic [LAGS_W-1:0] lags,
			input logic [TAP_W-1:0] k);
		logic [LAG_FIELD_W-1:0] raw;
		raw = lags[k*LAG_FIELD_W +: LAG_FIELD_W];
		if (int'(raw) > MAX_LAG) begin
			return IDX_W'(MAX_LAG);
		end
		return IDX_W'(raw);
	endfunction

endpackage

// ----- hdl/tapped_delay_line.sv -----
// tapped delay line top level: config registers, tap sequencer and result register
//
//  channel  dir  payload                                         accepted when
//  s_*      in   tdata: sample_0..3, tuser: cmd                   s_tvalid & s_tready
//  m_*      out  tdata: delayed_0..3, tuser: awake, tap_index    m_tvalid & m_tready
//  cfg_*    in   cfg_index, cfg_data                              cfg_valid & cfg_ready
//
// a sample gives one result per active tap (tap_count, zero taken as one, capped at 8),
// one result per cycle while m_tready is not stalled, from the single history read port
// into the result register; an asleep sample gives one result and a restart none.
// the next item is taken in the cycle the last result of the current one is loaded.
// reset clears history, counter and registers; no clearing pass is needed.
// a stalled m_tready holds the result register and the sequencer, and so s_tready.
module tapped_delay_line (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tdl_pkg::VEC_W-1:0]        s_tdata,   // sample_0, sample_1, sample_2, sample_3
	input  logic [tdl_pkg::IN_USER_W-1:0]    s_tuser,   // cmd
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tdl_pkg::VEC_W-1:0]        m_tdata,   // delayed_0, delayed_1, delayed_2, delayed_3
	output logic [tdl_pkg::OUT_USER_W-1:0]   m_tuser,   // awake, tap_index
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tdl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tdl_pkg::*;

	logic [1:0]          sleep_mode_q;
	logic [SAMPLE_W-1:0] sleep_value_q;
	logic [TCNT_W-1:0]   tap_count_q;
	logic [LAGS_W-1:0]   tap_lags_q;

	logic [IDX_W-1:0]    step_count_q;
	logic                busy_q;
	logic                awake_q;
	logic [TAP_W-1:0]    k_q;

	logic                m_tvalid_q;
	logic [VEC_W-1:0]    m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic                m_tlast_q;

	logic [TCNT_W-1:0]   n_act;
	logic [IDX_W-1:0]    max_lag;
	logic                awake_now;
	logic                s_acc;
	logic                is_restart;
	logic                out_load;
	logic                last_now;
	logic [IDX_W-1:0]    rd_lag;
	vec_t                rd_vec;
	hist_ctl_t           hctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_mode_q  <= MODE_NONE;
			sleep_value_q <= '0;
			tap_count_q   <= TCNT_W'(1);
			tap_lags_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SLEEP_MODE:  sleep_mode_q  <= cfg_data[1:0];
				REG_SLEEP_VALUE: sleep_value_q <= cfg_data[SAMPLE_W-1:0];
				REG_TAP_COUNT:   tap_count_q   <= cfg_data[TCNT_W-1:0];
				REG_TAP_LAGS:    tap_lags_q    <= cfg_data[LAGS_W-1:0];
				default: ;
			endcase
		end
	end

	// active taps: zero counts as one, anything above the tap limit saturates
	always_comb begin
		if (tap_count_q == '0) begin
			n_act = TCNT_W'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			n_act = TCNT_W'(MAX_TAPS);
		end else begin
			n_act = tap_count_q;
		end
	end

	always_comb begin
		max_lag = '0;
		for (int k = 0; k < MAX_TAPS; k++) begin
			if (k < int'(n_act) && tap_lag(tap_lags_q, TAP_W'(k)) > max_lag) begin
				max_lag = tap_lag(tap_lags_q, TAP_W'(k));
			end
		end
	end

	assign awake_now  = (sleep_mode_q != MODE_NONE) || (step_count_q >= max_lag);
	assign is_restart = (s_tuser[0] == CMD_RESTART);
	assign out_load   = !m_tvalid_q || m_tready;
	assign last_now   = !awake_q || (({1'b0, k_q} + TCNT_W'(1)) == n_act);
	assign s_tready   = !busy_q || (out_load && last_now);
	assign s_acc      = s_tvalid && s_tready;

	// history reads at the edge the last result loads see the old contents
	always_comb begin
		hctl.push    = s_acc && !is_restart;
		hctl.restart = s_acc && is_restart;
		hctl.spread  = sleep_mode_q[1] && (step_count_q == '0);
		hctl.sample  = vec_t'(s_tdata);
		hctl.fill    = sleep_value_q;
	end

	assign rd_lag = tap_lag(tap_lags_q, k_q);

	tdl_history u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.rd_lag (rd_lag),
		.rd_vec (rd_vec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
		end else if (hctl.restart) begin
			step_count_q <= '0;
		end else if (hctl.push && int'(step_count_q) < MAX_LAG) begin
			step_count_q <= step_count_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			awake_q <= 1'b0;
			k_q     <= '0;
		end else if (hctl.push) begin
			busy_q  <= 1'b1;
			awake_q <= awake_now;
			k_q     <= '0;
		end else if (busy_q && out_load) begin
			if (last_now) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + TAP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= busy_q;
		end
	end

	// asleep result carries zeros and closes the sample
	always_ff @(posedge clk) begin
		if (out_load && busy_q) begin
			if (awake_q) begin
				m_tdata_q <= rd_vec;
				m_tuser_q <= {k_q, 1'b1};
				m_tlast_q <= last_now;
			end else begin
				m_tdata_q <= '0;
				m_tuser_q <= '0;
				m_tlast_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- hdl/tdl_history.sv -----
// history of sample vectors: shift line with restart fill and one read port
module tdl_history (
	input  logic               clk,
	input  logic               arst_n,
	input  tdl_pkg::hist_ctl_t ctl,
	input  logic [tdl_pkg::IDX_W-1:0] rd_lag,
	output tdl_pkg::vec_t      rd_vec
);
	import tdl_pkg::*;

	vec_t hist_q [DEPTH];
	vec_t fill_vec;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			fill_vec[l] = ctl.fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DEPTH; d++) begin
				hist_q[d] <= '0;
			end
		end else if (ctl.restart) begin
			for (int d = 0; d < DEPTH; d++) begin
				hist_q[d] <= fill_vec;
			end
		end else if (ctl.push) begin
			// first sample after restart in first-value mode fills every slot
			if (ctl.spread) begin
				for (int d = 0; d < DEPTH; d++) begin
					hist_q[d] <= ctl.sample;
				end
			end else begin
				hist_q[0] <= ctl.sample;
				for (int d = 1; d < DEPTH; d++) begin
					hist_q[d] <= hist_q[d-1];
				end
			end
		end
	end

	assign rd_vec = hist_q[rd_lag];

endmodule

// ----- tb/tb_tapped_delay_line.sv -----
// self-checking testbench for the tapped delay line: random stream traffic against a local predictor
`timescale 1ns / 1ps

module tb_tapped_delay_line;
	import tdl_pkg::*;

	localparam int LIMIT      = 300000;
	localparam int SETTLE     = 24;
	localparam int HOLD_LEN   = 400;
	localparam int RAND_ITEMS = 200;

	typedef struct {
		bit   drain;
		logic cmd;
		vec_t smp;
	} line_item_t;

	typedef struct {
		logic             awake;
		logic [TAP_W-1:0] tap;
		vec_t             lanes;
		logic             last;
	} tap_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [VEC_W-1:0]      s_tdata   = '0;
	logic [IN_USER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [VEC_W-1:0]      m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state
	logic [1:0]        cur_mode  = MODE_NONE;
	logic [15:0]       cur_sleep = '0;
	logic [TCNT_W-1:0] cur_tcnt  = TCNT_W'(1);
	logic [LAGS_W-1:0] cur_lags  = '0;
	vec_t              line_mem [DEPTH];
	int                steps     = 0;

	line_item_t  pend_q [$];
	tap_result_t tap_q [$];

	bit failed    = 1'b0;
	bit s_took    = 1'b0;
	bit want_hold = 1'b0;
	int snd_idle  = 0;
	int rcv_idle  = 0;
	int cycles    = 0;

	tapped_delay_line u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		for (int d = 0; d < DEPTH; d++) begin
			line_mem[d] = '0;
		end
	end

	function automatic int lag_at(input int k);
		int v;
		v = (k < LAG_WORDS) ? int'(cur_lags[k*LAG_FIELD_W +: LAG_FIELD_W]) : 0;
		return (v > MAX_LAG) ? MAX_LAG : v;
	endfunction

	// shift one accepted item through the line and queue the tap results it causes
	task automatic advance_line(input logic cmd, input vec_t smp);
		int n;
		int deepest;
		bit awake;
		tap_result_t r;
		if (cmd == CMD_RESTART) begin
			for (int d = 0; d < DEPTH; d++) begin
				line_mem[d] = vec_t'({LANES{cur_sleep}});
			end
			steps = 0;
			return;
		end
		n = (cur_tcnt == 0) ? 1 : (int'(cur_tcnt) > MAX_TAPS) ? MAX_TAPS : int'(cur_tcnt);
		deepest = 0;
		for (int k = 0; k < n; k++) begin
			if (lag_at(k) > deepest) begin
				deepest = lag_at(k);
			end
		end
		awake = (cur_mode != MODE_NONE) || (steps >= deepest);
		for (int d = DEPTH - 1; d > 0; d--) begin
			line_mem[d] = line_mem[d-1];
		end
		line_mem[0] = smp;
		// first sample after a restart spreads over the whole line (mode 3 behaves as mode 2)
		if (cur_mode >= MODE_FIRST && steps == 0) begin
			for (int d = 1; d < DEPTH; d++) begin
				line_mem[d] = smp;
			end
		end
		if (steps < MAX_LAG) begin
			steps++;
		end
		if (!awake) begin
			r.awake = 1'b0;
			r.tap   = '0;
			r.lanes = '0;
			r.last  = 1'b1;
			tap_q.push_back(r);
			return;
		end
		for (int k = 0; k < n; k++) begin
			r.awake = 1'b1;
			r.tap   = TAP_W'(k);
			r.lanes = line_mem[lag_at(k)];
			r.last  = (k == n - 1);
			tap_q.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// monitor: input acceptance feeds the predictor, output acceptance is checked
	always @(posedge clk) begin : monitor
		tap_result_t e;
		vec_t got;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		s_took <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_line(s_tuser[0], vec_t'(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (tap_q.size() == 0) begin
					$error("tap result with nothing expected");
					failed = 1'b1;
				end else begin
					e   = tap_q.pop_front();
					got = vec_t'(m_tdata);
					check_field("awake", e.awake, m_tuser[0]);
					check_field("tap_index", e.tap, m_tuser[OUT_USER_W-1:1]);
					for (int l = 0; l < LANES; l++) begin
						check_field($sformatf("delayed_%0d", l),
							longint'($signed(e.lanes[l])), longint'($signed(got[l])));
					end
					check_field("last", e.last, m_tlast);
				end
			end
		end
	end

	// sender: offers queued items, a drain mark holds it until all results are back
	always @(negedge clk) begin : sender
		line_item_t cur;
		bit busy;
		busy = s_tvalid && !s_took;
		if (!busy) begin
			if (pend_q.size() != 0 && pend_q[0].drain && tap_q.size() == 0) begin
				void'(pend_q.pop_front());
			end
			if (arst_n && pend_q.size() != 0 && !pend_q[0].drain
					&& $urandom_range(99) >= snd_idle) begin
				cur = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= cur.cmd;
				s_tdata  <= cur.smp;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	always @(negedge clk) begin : receiver
		int hold_left;
		if (want_hold) begin
			hold_left = HOLD_LEN;
			want_hold = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SLEEP_MODE:  cur_mode  = val[1:0];
			REG_SLEEP_VALUE: cur_sleep = val[15:0];
			REG_TAP_COUNT:   cur_tcnt  = val[TCNT_W-1:0];
			REG_TAP_LAGS:    cur_lags  = val[LAGS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_line(input logic [1:0] mode, input logic [15:0] fill,
			input logic [TCNT_W-1:0] taps, input logic [LAGS_W-1:0] lags);
		write_reg(REG_SLEEP_MODE, CFG_DATA_W'(mode));
		write_reg(REG_SLEEP_VALUE, CFG_DATA_W'(fill));
		write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
		write_reg(REG_TAP_LAGS, CFG_DATA_W'(lags));
	endtask

	// wait until the block has gone quiet
	task automatic settle();
		do @(posedge clk); while (pend_q.size() != 0 || s_tvalid || tap_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_item(input logic cmd, input vec_t smp);
		line_item_t it;
		it.drain = 1'b0;
		it.cmd   = cmd;
		it.smp   = smp;
		pend_q.push_back(it);
	endtask

	task automatic add_drain();
		line_item_t it;
		it.drain = 1'b1;
		it.cmd   = CMD_SAMPLE;
		it.smp   = '0;
		pend_q.push_back(it);
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic vec_t rand_vec();
		vec_t v;
		for (int l = 0; l < LANES; l++) begin
			v[l] = rand_word();
		end
		return v;
	endfunction

	function automatic logic [LAGS_W-1:0] rand_lags();
		logic [LAGS_W-1:0] v;
		for (int k = 0; k < LAG_WORDS; k++) begin
			case ($urandom_range(9))
				0:       v[k*LAG_FIELD_W +: LAG_FIELD_W] = 5'd31;
				1, 2:    v[k*LAG_FIELD_W +: LAG_FIELD_W] = 5'($urandom);
				default: v[k*LAG_FIELD_W +: LAG_FIELD_W] = 5'($urandom_range(7));
			endcase
		end
		return v;
	endfunction

	initial begin : stimulus
		int done;
		int len;
		bit held;
		snd_idle = 6;
		rcv_idle = 72;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one tap at lag 0, always awake
		add_item(CMD_SAMPLE, {16'hffff, 16'h0000, 16'h8000, 16'h7fff});
		add_item(CMD_SAMPLE, {16'h0000, 16'hffff, 16'h7fff, 16'h8000});
		add_item(CMD_SAMPLE, {16'h89ab, 16'h4567, 16'hcdef, 16'h0123});
		settle();

		// no sleep value, tap count zero, lag 3: three asleep samples first
		set_line(MODE_NONE, 16'h8000, '0, LAGS_W'(3));
		add_item(CMD_RESTART, '0);
		for (int i = 0; i < 5; i++) begin
			add_item(CMD_SAMPLE, rand_vec());
		end
		settle();

		// fixed sleep value, tap count above range, deepest lags
		set_line(MODE_FIXED, 16'h7fff, 4'd15,
			{5'd7, 5'd30, 5'd5, 5'd2, 5'd31, 5'd1, 5'd0, 5'd31});
		add_item(CMD_RESTART, '0);
		for (int i = 0; i < 3; i++) begin
			add_item(CMD_SAMPLE, rand_vec());
		end
		settle();

		// unused mode code, behaves as first-sample fill
		set_line(2'd3, 16'h1234, 4'd8, rand_lags());
		add_item(CMD_RESTART, '0);
		add_item(CMD_RESTART, '0);
		add_item(CMD_SAMPLE, rand_vec());
		add_item(CMD_SAMPLE, rand_vec());
		settle();

		set_line(MODE_FIRST, 16'hffff, 4'd2, {30'd0, 5'd31, 5'd1});
		add_item(CMD_RESTART, '0);
		add_item(CMD_SAMPLE, rand_vec());
		add_item(CMD_SAMPLE, rand_vec());
		settle();

		done = 0;
		held = 1'b0;
		while (done < RAND_ITEMS) begin
			if (done >= 2 * RAND_ITEMS / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (done >= RAND_ITEMS / 3) begin
				snd_idle = 72;
				rcv_idle = 6;
			end
			set_line(2'($urandom_range(3)), rand_word(),
				($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
				rand_lags());
			// mostly a restart followed by a long run of samples, some stray restarts
			len = $urandom_range(20, 40);
			if ($urandom_range(4) != 0) begin
				add_item(CMD_RESTART, '0);
				done++;
			end
			for (int i = 0; i < len; i++) begin
				if (i == len / 2) begin
					add_drain();
				end
				add_item(($urandom_range(19) == 0) ? CMD_RESTART : CMD_SAMPLE, rand_vec());
			end
			done += len;
			if (snd_idle == 0 && !held) begin
				want_hold = 1'b1;
				held = 1'b1;
			end
			settle();
		end

		if (!failed) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
